// ===== hw/rtl/frc_pkg.sv =====
// ============================================================================
// frc_pkg - shared types and constants of the feedback ring-out controller
// Frame and result item layouts, configuration set, action and stop codes,
// controller phase and the fixed sizes of the analyzer and EQ.
// ============================================================================
package frc_pkg;

	// Analyzer and EQ sizes
	localparam int NUM_BANDS = 32;
	localparam int NUM_BINS  = 100;
	localparam int BAND_W    = 5;
	localparam int BIN_W     = 7;

	// Notch cut applied when a notch is placed, dB x16
	localparam logic signed [15:0] CUT_DEPTH = -16'sd192;

	// Marker for "no bin being confirmed"
	localparam logic [BIN_W-1:0] NO_BIN = 7'd127;

	// Configuration reset values
	localparam logic signed [15:0] START_GAIN_RST     = 16'sd0;
	localparam logic [14:0]        GAIN_STEP_RST      = 15'd16;
	localparam logic signed [15:0] GAIN_CEILING_RST   = 16'sd160;
	localparam logic [14:0]        TARGET_MARGIN_RST  = 15'd0;
	localparam logic [7:0]         SETTLE_LEN_RST     = 8'd4;
	localparam logic [7:0]         CONFIRM_LEN_RST    = 8'd3;
	localparam logic [7:0]         QUIET_LEN_RST      = 8'd8;
	localparam logic [5:0]         NOTCH_LIMIT_RST    = 6'd8;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_START_GAIN     = 3'd0,
		CFG_GAIN_STEP      = 3'd1,
		CFG_GAIN_CEILING   = 3'd2,
		CFG_TARGET_MARGIN  = 3'd3,
		CFG_SETTLE_LEN     = 3'd4,
		CFG_CONFIRM_LEN    = 3'd5,
		CFG_QUIET_LEN      = 3'd6,
		CFG_NOTCH_LIMIT    = 3'd7
	} cfg_idx_t;

	// Result action codes
	typedef enum logic [2:0] {
		ACT_HOLD    = 3'd0,
		ACT_BACKOFF = 3'd1,
		ACT_RAISE   = 3'd2,
		ACT_NOTCH   = 3'd3,
		ACT_DONE    = 3'd4,
		ACT_ABORT   = 3'd5
	} action_t;

	// Stop reason codes
	typedef enum logic [2:0] {
		WHY_NONE    = 3'd0,
		WHY_CEILING = 3'd1,
		WHY_MARGIN  = 3'd2,
		WHY_MAXN    = 3'd3,
		WHY_ABORT   = 3'd4
	} reason_t;

	// Controller phase
	typedef enum logic [1:0] {
		PH_ANALYZE = 2'd0,
		PH_SETTLE  = 2'd1,
		PH_DONE    = 2'd2
	} phase_t;

	// One analysis frame item
	typedef struct packed {
		logic             ring_found;
		logic [BIN_W-1:0] peak_bin;
		logic [BAND_W-1:0] band;
	} frame_t;

	// One result item
	typedef struct packed {
		action_t            action;
		logic signed [15:0] gain_out;
		logic [BAND_W-1:0]  notch_band;
		logic signed [15:0] cut_depth;
		reason_t            stop_reason;
		logic signed [15:0] achieved_margin;
	} result_t;

	// Configuration register set
	typedef struct packed {
		logic signed [15:0] start_gain;
		logic [14:0]        gain_step;
		logic signed [15:0] gain_ceiling;
		logic [14:0]        target_margin;
		logic [7:0]         settle_len;
		logic [7:0]         confirm_len;
		logic [7:0]         quiet_len;
		logic [5:0]         notch_limit;
	} cfg_t;

	// Control from the handshake logic to the controller core
	typedef struct packed {
		logic               step_en;
		logic               gain_load;
		logic signed [15:0] gain_value;
	} core_ctl_t;

endpackage

// ===== hw/rtl/frc_core.sv =====
// ============================================================================
// frc_core - ring-out decision logic and controller state
// Classifies one registered frame against the controller state, produces the
// result item and updates the state in the same cycle when stepped.
// ============================================================================
module frc_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  frc_pkg::cfg_t         cfg,
	input  frc_pkg::core_ctl_t    ctl,
	input  frc_pkg::frame_t       frame,
	output frc_pkg::result_t      result
);

	// Outcome of one frame
	typedef enum logic [3:0] {
		FC_DONE,
		FC_BACKOFF,
		FC_SETTLE,
		FC_ABORT,
		FC_TRACK,
		FC_NOTCH,
		FC_QUIET,
		FC_STOP_MAXN,
		FC_STOP_MARGIN,
		FC_STOP_CEIL,
		FC_RAISE
	} frame_case_t;

	frc_pkg::phase_t                    phase_q, phase_d;
	logic [7:0]                         settle_left_q, settle_left_d;
	logic [7:0]                         quiet_run_q, quiet_run_d;
	logic [7:0]                         confirm_run_q, confirm_run_d;
	logic [frc_pkg::BIN_W-1:0]          confirm_target_q, confirm_target_d;
	logic                               backoff_pending_q, backoff_pending_d;
	logic signed [15:0]                 current_gain_q, current_gain_d;
	logic [5:0]                         notch_count_q, notch_count_d;
	logic [frc_pkg::NUM_BANDS-1:0]      band_notched_q, band_notched_d;
	frc_pkg::reason_t                   final_reason_q, final_reason_d;
	logic signed [15:0]                 final_margin_q, final_margin_d;

	frame_case_t                        fc;
	logic [frc_pkg::BAND_W-1:0]         band_c;
	logic [7:0]                         cr_eff, q_eff, cr_next, q_next;
	logic signed [16:0]                 gain_dn, gain_up, margin_w;
	logic signed [15:0]                 gain_backoff, margin_sat;

	// Clamp band, derive run counts and gain arithmetic
	always_comb begin
		if ({1'b0, frame.band} >= (frc_pkg::BAND_W+1)'(frc_pkg::NUM_BANDS)) begin
			band_c = frc_pkg::BAND_W'(frc_pkg::NUM_BANDS - 1);
		end else begin
			band_c = frame.band;
		end

		// leaving settle restarts all runs
		cr_eff = (phase_q == frc_pkg::PH_ANALYZE) ? confirm_run_q : 8'd0;
		q_eff  = (phase_q == frc_pkg::PH_ANALYZE) ? quiet_run_q : 8'd0;

		if (cr_eff != 8'd0 && frame.peak_bin == confirm_target_q) begin
			cr_next = (cr_eff == 8'hFF) ? cr_eff : cr_eff + 8'd1;
		end else begin
			cr_next = 8'd1;
		end
		q_next = (q_eff == 8'hFF) ? q_eff : q_eff + 8'd1;

		gain_dn = {current_gain_q[15], current_gain_q} - $signed({2'b00, cfg.gain_step});
		gain_up = {current_gain_q[15], current_gain_q} + $signed({2'b00, cfg.gain_step});
		margin_w = {current_gain_q[15], current_gain_q} -
			{cfg.start_gain[15], cfg.start_gain};

		// back-off never goes below the start gain
		if (gain_dn < $signed({cfg.start_gain[15], cfg.start_gain})) begin
			gain_backoff = cfg.start_gain;
		end else begin
			gain_backoff = gain_dn[15:0];
		end

		// saturate margin to 16 signed bits
		if (margin_w[16] != margin_w[15]) begin
			margin_sat = margin_w[16] ? 16'sh8000 : 16'sh7FFF;
		end else begin
			margin_sat = margin_w[15:0];
		end
	end

	// Classify the frame
	always_comb begin
		if (phase_q == frc_pkg::PH_DONE) begin
			fc = FC_DONE;
		end else if (backoff_pending_q) begin
			fc = FC_BACKOFF;
		end else if (phase_q == frc_pkg::PH_SETTLE && settle_left_q != 8'd0) begin
			fc = FC_SETTLE;
		end else if (frame.ring_found) begin
			if (band_notched_q[band_c]) begin
				fc = FC_ABORT;
			end else if (cr_next >= cfg.confirm_len) begin
				fc = FC_NOTCH;
			end else begin
				fc = FC_TRACK;
			end
		end else if (q_next < cfg.quiet_len) begin
			fc = FC_QUIET;
		end else if (notch_count_q >= cfg.notch_limit) begin
			fc = FC_STOP_MAXN;
		end else if (cfg.target_margin != 15'd0 &&
				margin_w >= $signed({2'b00, cfg.target_margin})) begin
			fc = FC_STOP_MARGIN;
		end else if (gain_up > $signed({cfg.gain_ceiling[15], cfg.gain_ceiling})) begin
			fc = FC_STOP_CEIL;
		end else begin
			fc = FC_RAISE;
		end
	end

	// Next state
	always_comb begin
		phase_d           = phase_q;
		settle_left_d     = settle_left_q;
		quiet_run_d       = quiet_run_q;
		confirm_run_d     = confirm_run_q;
		confirm_target_d  = confirm_target_q;
		backoff_pending_d = backoff_pending_q;
		current_gain_d    = current_gain_q;
		notch_count_d     = notch_count_q;
		band_notched_d    = band_notched_q;
		final_reason_d    = final_reason_q;
		final_margin_d    = final_margin_q;
		case (fc)
			FC_DONE: begin
			end
			FC_BACKOFF: begin
				backoff_pending_d = 1'b0;
				current_gain_d    = gain_backoff;
				phase_d           = frc_pkg::PH_SETTLE;
				settle_left_d     = cfg.settle_len;
			end
			FC_SETTLE: begin
				settle_left_d = settle_left_q - 8'd1;
			end
			FC_ABORT: begin
				phase_d        = frc_pkg::PH_DONE;
				confirm_run_d  = cr_eff;
				quiet_run_d    = q_eff;
				final_reason_d = frc_pkg::WHY_ABORT;
				final_margin_d = margin_sat;
			end
			FC_TRACK: begin
				phase_d          = frc_pkg::PH_ANALYZE;
				confirm_run_d    = cr_next;
				confirm_target_d = frame.peak_bin;
				quiet_run_d      = 8'd0;
			end
			FC_NOTCH: begin
				phase_d                = frc_pkg::PH_ANALYZE;
				confirm_run_d          = 8'd0;
				confirm_target_d       = frc_pkg::NO_BIN;
				quiet_run_d            = 8'd0;
				band_notched_d[band_c] = 1'b1;
				notch_count_d          = (notch_count_q == 6'h3F) ? notch_count_q
					: notch_count_q + 6'd1;
				backoff_pending_d      = 1'b1;
			end
			FC_QUIET: begin
				phase_d          = frc_pkg::PH_ANALYZE;
				confirm_run_d    = 8'd0;
				confirm_target_d = frc_pkg::NO_BIN;
				quiet_run_d      = q_next;
			end
			FC_STOP_MAXN, FC_STOP_MARGIN, FC_STOP_CEIL: begin
				phase_d          = frc_pkg::PH_DONE;
				confirm_run_d    = 8'd0;
				confirm_target_d = frc_pkg::NO_BIN;
				quiet_run_d      = 8'd0;
				final_margin_d   = margin_sat;
				if (fc == FC_STOP_MAXN) begin
					final_reason_d = frc_pkg::WHY_MAXN;
				end else if (fc == FC_STOP_MARGIN) begin
					final_reason_d = frc_pkg::WHY_MARGIN;
				end else begin
					final_reason_d = frc_pkg::WHY_CEILING;
				end
			end
			FC_RAISE: begin
				confirm_run_d    = 8'd0;
				confirm_target_d = frc_pkg::NO_BIN;
				quiet_run_d      = 8'd0;
				current_gain_d   = gain_up[15:0];
				phase_d          = frc_pkg::PH_SETTLE;
				settle_left_d    = cfg.settle_len;
			end
			default: begin
			end
		endcase
	end

	// Result item
	always_comb begin
		result.action          = frc_pkg::ACT_HOLD;
		result.gain_out        = current_gain_q;
		result.notch_band      = '0;
		result.cut_depth       = 16'sd0;
		result.stop_reason     = final_reason_d;
		result.achieved_margin = final_margin_d;
		case (fc)
			FC_DONE: begin
				result.action = frc_pkg::ACT_DONE;
			end
			FC_BACKOFF: begin
				result.action   = frc_pkg::ACT_BACKOFF;
				result.gain_out = gain_backoff;
			end
			FC_ABORT: begin
				result.action   = frc_pkg::ACT_ABORT;
				result.gain_out = cfg.start_gain;
			end
			FC_NOTCH: begin
				result.action     = frc_pkg::ACT_NOTCH;
				result.notch_band = band_c;
				result.cut_depth  = frc_pkg::CUT_DEPTH;
			end
			FC_STOP_MAXN, FC_STOP_MARGIN, FC_STOP_CEIL: begin
				result.action = frc_pkg::ACT_DONE;
			end
			FC_RAISE: begin
				result.action   = frc_pkg::ACT_RAISE;
				result.gain_out = gain_up[15:0];
			end
			default: begin
			end
		endcase
	end

	// State registers: advance on each stepped frame, reload gain on a start-gain write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q           <= frc_pkg::PH_ANALYZE;
			settle_left_q     <= 8'd0;
			quiet_run_q       <= 8'd0;
			confirm_run_q     <= 8'd0;
			confirm_target_q  <= frc_pkg::NO_BIN;
			backoff_pending_q <= 1'b0;
			current_gain_q    <= frc_pkg::START_GAIN_RST;
			notch_count_q     <= 6'd0;
			band_notched_q    <= '0;
			final_reason_q    <= frc_pkg::WHY_NONE;
			final_margin_q    <= 16'sd0;
		end else if (ctl.gain_load) begin
			current_gain_q <= ctl.gain_value;
		end else if (ctl.step_en) begin
			phase_q           <= phase_d;
			settle_left_q     <= settle_left_d;
			quiet_run_q       <= quiet_run_d;
			confirm_run_q     <= confirm_run_d;
			confirm_target_q  <= confirm_target_d;
			backoff_pending_q <= backoff_pending_d;
			current_gain_q    <= current_gain_d;
			notch_count_q     <= notch_count_d;
			band_notched_q    <= band_notched_d;
			final_reason_q    <= final_reason_d;
			final_margin_q    <= final_margin_d;
		end
	end

endmodule

// ===== hw/rtl/feedback_ringout_controller.sv =====
// ============================================================================
// feedback_ringout_controller - feedback ring-out gain and notch sequencer
// Frame-by-frame ring confirmation, notch placement, gain back-off and raise.
// ============================================================================
// Usage:
//  frame channel (frame_valid / frame_stall / frame) carries one analyzer
//  result per frame: ring flag, peak bin and the EQ band of that bin.
//  result channel (result_valid / result_stall / result) returns exactly one
//  item per frame: action, gain to apply, notch band and cut, and the stop
//  reason and achieved margin once the run has finished.
//  cfg_we / cfg_index / cfg_data write the eight setup registers; write them
//  only while no frame is in flight. Writing start_gain also loads the
//  current gain.
//  Path: the frame register loads when a frame is accepted, and the result
//  register loads from it through the decision logic when the frame advances.
//  Throughput: one frame per cycle while no result is stalled; the whole
//  decision is one pass of logic between the frame register and the result
//  register.
//  Reset clears all controller state and returns the registers to defaults.
//  A stalled result holds; the frame register keeps one more frame, and then
//  frame_stall rises until the result is taken.
// ============================================================================
module feedback_ringout_controller (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              frame_valid,
	output logic              frame_stall,
	input  frc_pkg::frame_t   frame,
	output logic              result_valid,
	input  logic              result_stall,
	output frc_pkg::result_t  result,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data
);

	frc_pkg::cfg_t      cfg_q;
	frc_pkg::frame_t    frame_s1;
	logic               valid_s1;
	logic               out_free;
	logic               advance;
	frc_pkg::core_ctl_t ctl;
	frc_pkg::result_t   result_c;

	// Handshake: result register empty or being taken lets the frame advance
	assign out_free    = !result_valid || !result_stall;
	assign advance     = valid_s1 && out_free;
	assign frame_stall = valid_s1 && !out_free;

	assign ctl.step_en    = advance;
	assign ctl.gain_load  = cfg_we && (cfg_index == frc_pkg::CFG_START_GAIN);
	assign ctl.gain_value = cfg_data;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_gain    <= frc_pkg::START_GAIN_RST;
			cfg_q.gain_step     <= frc_pkg::GAIN_STEP_RST;
			cfg_q.gain_ceiling  <= frc_pkg::GAIN_CEILING_RST;
			cfg_q.target_margin <= frc_pkg::TARGET_MARGIN_RST;
			cfg_q.settle_len    <= frc_pkg::SETTLE_LEN_RST;
			cfg_q.confirm_len   <= frc_pkg::CONFIRM_LEN_RST;
			cfg_q.quiet_len     <= frc_pkg::QUIET_LEN_RST;
			cfg_q.notch_limit   <= frc_pkg::NOTCH_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				frc_pkg::CFG_START_GAIN:    cfg_q.start_gain    <= cfg_data;
				frc_pkg::CFG_GAIN_STEP:     cfg_q.gain_step     <= cfg_data[14:0];
				frc_pkg::CFG_GAIN_CEILING:  cfg_q.gain_ceiling  <= cfg_data;
				frc_pkg::CFG_TARGET_MARGIN: cfg_q.target_margin <= cfg_data[14:0];
				frc_pkg::CFG_SETTLE_LEN:    cfg_q.settle_len    <= cfg_data[7:0];
				frc_pkg::CFG_CONFIRM_LEN:   cfg_q.confirm_len   <= cfg_data[7:0];
				frc_pkg::CFG_QUIET_LEN:     cfg_q.quiet_len     <= cfg_data[7:0];
				frc_pkg::CFG_NOTCH_LIMIT:   cfg_q.notch_limit   <= cfg_data[5:0];
				default: begin
				end
			endcase
		end
	end

	// Frame register: load on accept, drop when advanced
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame_valid && !frame_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_valid && !frame_stall) begin
			frame_s1 <= frame;
		end
	end

	frc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.ctl    (ctl),
		.frame  (frame_s1),
		.result (result_c)
	);

	// Result register: load on advance, clear once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result <= result_c;
		end
	end

endmodule

// ===== hw/rtl/frc_check.sv =====
// ============================================================================
// frc_check - port-level checks of the feedback ring-out controller
// Result item consistency and handshake behavior, bound to the top level.
// ============================================================================
module frc_check (
	input logic              clk,
	input logic              arst_n,
	input logic              frame_stall,
	input logic              result_valid,
	input logic              result_stall,
	input frc_pkg::result_t  result
);

	// Hold a stalled result
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result item changed");

	// Never stall frames while the result register is empty
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !frame_stall)
		else $error("frame stalled with empty result register");

	// Notch band and cut only on a notch item
	a_notch_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.action != frc_pkg::ACT_NOTCH |->
			result.notch_band == '0 && result.cut_depth == 16'sd0)
		else $error("notch fields set on a non-notch item");

	a_notch_cut: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.action == frc_pkg::ACT_NOTCH |->
			result.cut_depth == frc_pkg::CUT_DEPTH &&
			result.stop_reason == frc_pkg::WHY_NONE)
		else $error("notch item with wrong cut or after stop");

	// A finished run always carries its reason
	a_stop_reason: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.action == frc_pkg::ACT_DONE ||
			result.action == frc_pkg::ACT_ABORT) |->
			result.stop_reason != frc_pkg::WHY_NONE)
		else $error("done or abort without stop reason");

endmodule

bind feedback_ringout_controller frc_check u_frc_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.frame_stall  (frame_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
